// ===== rtl/core/pkbe_pkg.sv =====
// ============================================================================
// pkbe_pkg
// Shared types and constants of the prefix-key block entry parser.
// ============================================================================
package pkbe_pkg;

    // Width of the region length and offset counters.
    localparam int REGION_BITS = 24;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 24;
    localparam int LEN_W     = 32;
    localparam int KEY_POS_W = 24;

    // A header holds three lengths, and needs at least one byte for each.
    localparam int MIN_HEADER_BYTES = 3;

    // A varint32 may take at most five bytes.
    localparam logic [2:0] VARINT_LAST_BYTE = 3'd4;
    localparam logic [1:0] VARINT_LAST_IDX  = 2'd2;

    typedef enum logic [1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_KEY     = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_DISCARD = 2'd3
    } t_role;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_SHORT_HEADER = 3'd1,
        ERR_BAD_VARINT   = 3'd2,
        ERR_PREFIX_LONG  = 3'd3,
        ERR_OVERRUN      = 3'd4
    } t_err;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_KEY    = 4'b0010,
        PH_VALUE  = 4'b0100,
        PH_ERROR  = 4'b1000
    } t_phase;

    // One result item as produced by the parser core.
    typedef struct packed {
        t_role                  role;
        logic [BYTE_W-1:0]      data;
        logic [KEY_POS_W-1:0]   key_pos;
        logic [LEN_W-1:0]       shared_len;
        logic [LEN_W-1:0]       delta_len;
        logic [LEN_W-1:0]       value_len;
        logic                   header_done;
        logic                   entry_done;
        logic                   region_done;
        t_err                   err;
    } t_result;

endpackage

// ===== rtl/core/pkbe_if.sv =====
// ============================================================================
// pkbe_if
// Valid/ready channels for the input bytes and the result items.
// ============================================================================
interface pkbe_in_if;
    logic                          valid;
    logic                          ready;
    logic [pkbe_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface pkbe_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      byte_role;
    logic [pkbe_pkg::BYTE_W-1:0]     data_out;
    logic [pkbe_pkg::KEY_POS_W-1:0]  key_position;
    logic [pkbe_pkg::LEN_W-1:0]      shared_len;
    logic [pkbe_pkg::LEN_W-1:0]      delta_len;
    logic [pkbe_pkg::LEN_W-1:0]      value_len;
    logic                            header_done;
    logic                            entry_done;
    logic                            region_done;
    logic [2:0]                      error_code;

    modport source (
        output valid, output byte_role, output data_out, output key_position,
        output shared_len, output delta_len, output value_len,
        output header_done, output entry_done, output region_done,
        output error_code, input ready
    );
    modport sink (
        input valid, input byte_role, input data_out, input key_position,
        input shared_len, input delta_len, input value_len,
        input header_done, input entry_done, input region_done,
        input error_code, output ready
    );
endinterface

// ===== rtl/core/pkbe_parse_core.sv =====
// ============================================================================
// pkbe_parse_core
// Parser state and the per-byte decode step of the entry region.
// ============================================================================
module pkbe_parse_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [pkbe_pkg::BYTE_W-1:0]         i_byte,
    input  logic [pkbe_pkg::REGION_BITS-1:0]    i_region_len,
    output pkbe_pkg::t_result                   o_res
);

    localparam int RB = pkbe_pkg::REGION_BITS;
    localparam int LW = pkbe_pkg::LEN_W;

    logic [RB-1:0]             r_offset, n_offset;
    pkbe_pkg::t_phase          r_phase, n_phase;
    logic [1:0]                r_vidx, n_vidx;
    logic [2:0]                r_vcnt, n_vcnt;
    logic [LW-1:0]             r_acc, n_acc;
    logic [LW-1:0]             r_shared, n_shared;
    logic [LW-1:0]             r_delta, n_delta;
    logic [LW-1:0]             r_value, n_value;
    logic [LW-1:0]             r_prev, n_prev;
    logic [RB-1:0]             r_left, n_left;
    logic [pkbe_pkg::KEY_POS_W-1:0] r_key_pos, n_key_pos;

    logic                      in_region;
    logic                      last;
    logic                      short_hdr;
    logic [RB-1:0]             left_after;
    logic                      hdr_start;
    logic [LW-1:0]             acc_term;
    logic [LW-1:0]             acc_new;
    logic [LW:0]               body_sum;
    logic                      overrun;
    logic [LW:0]               key_sum;
    logic [LW-1:0]             key_len_sat;
    logic                      clear;
    pkbe_pkg::t_err            err;
    pkbe_pkg::t_result         res;

    // Position tests against the region length, one bit wider than the offset.
    assign in_region  = r_offset < i_region_len;
    assign last       = ({1'b0, r_offset} + {{RB{1'b0}}, 1'b1}) == {1'b0, i_region_len};
    assign short_hdr  = {1'b0, i_region_len} <
                        ({1'b0, r_offset} + (RB+1)'(pkbe_pkg::MIN_HEADER_BYTES));
    assign left_after = i_region_len - r_offset - {{(RB-1){1'b0}}, 1'b1};

    // Seven payload bits land at the slot given by the byte count; the fifth byte gives four.
    assign hdr_start = (r_vidx == 2'd0) && (r_vcnt == 3'd0);
    always_comb begin
        case (r_vcnt)
            3'd0:    acc_term = {25'd0, i_byte[6:0]};
            3'd1:    acc_term = {18'd0, i_byte[6:0], 7'd0};
            3'd2:    acc_term = {11'd0, i_byte[6:0], 14'd0};
            3'd3:    acc_term = {4'd0, i_byte[6:0], 21'd0};
            3'd4:    acc_term = {i_byte[3:0], 28'd0};
            default: acc_term = '0;
        endcase
    end
    assign acc_new = (hdr_start ? '0 : r_acc) | acc_term;

    // Overrun test on the final length byte: delta plus value without wrap.
    assign body_sum = {1'b0, r_delta} + {1'b0, acc_new};
    assign overrun  = body_sum > {{(LW+1-RB){1'b0}}, left_after};

    // Rebuilt key length, saturated to 32 bits.
    assign key_sum     = {1'b0, r_shared} + {1'b0, r_delta};
    assign key_len_sat = key_sum[LW] ? '1 : key_sum[LW-1:0];

    always_comb begin
        n_offset  = r_offset;
        n_phase   = r_phase;
        n_vidx    = r_vidx;
        n_vcnt    = r_vcnt;
        n_acc     = r_acc;
        n_shared  = r_shared;
        n_delta   = r_delta;
        n_value   = r_value;
        n_prev    = r_prev;
        n_left    = r_left;
        n_key_pos = r_key_pos;
        err       = pkbe_pkg::ERR_NONE;
        clear     = 1'b0;

        res             = '0;
        res.role        = pkbe_pkg::ROLE_HEADER;
        res.data        = i_byte;
        res.err         = pkbe_pkg::ERR_NONE;

        if (!in_region) begin
            res.role        = pkbe_pkg::ROLE_DISCARD;
            res.region_done = 1'b1;
            clear           = 1'b1;
        end else begin
            case (r_phase)
                pkbe_pkg::PH_ERROR: begin
                    res.role = pkbe_pkg::ROLE_DISCARD;
                end
                pkbe_pkg::PH_KEY: begin
                    res.role    = pkbe_pkg::ROLE_KEY;
                    res.key_pos = r_key_pos;
                    n_key_pos   = r_key_pos + 1'b1;
                    n_left      = r_left - 1'b1;
                    if (r_left == {{(RB-1){1'b0}}, 1'b1}) begin
                        if (r_value != '0) begin
                            n_phase = pkbe_pkg::PH_VALUE;
                            n_left  = r_value[RB-1:0];
                        end else begin
                            res.entry_done = 1'b1;
                            n_phase        = pkbe_pkg::PH_HEADER;
                        end
                    end
                end
                pkbe_pkg::PH_VALUE: begin
                    res.role = pkbe_pkg::ROLE_VALUE;
                    n_left   = r_left - 1'b1;
                    if (r_left == {{(RB-1){1'b0}}, 1'b1}) begin
                        res.entry_done = 1'b1;
                        n_phase        = pkbe_pkg::PH_HEADER;
                    end
                end
                default: begin
                    res.role = pkbe_pkg::ROLE_HEADER;
                    if (hdr_start) begin
                        n_shared = '0;
                        n_delta  = '0;
                        n_value  = '0;
                        n_acc    = '0;
                        if (short_hdr) begin
                            err = pkbe_pkg::ERR_SHORT_HEADER;
                        end
                    end
                    if (err == pkbe_pkg::ERR_NONE) begin
                        n_acc = acc_new;
                        if (i_byte[7]) begin
                            if ((r_vcnt >= pkbe_pkg::VARINT_LAST_BYTE) || last) begin
                                err = pkbe_pkg::ERR_BAD_VARINT;
                            end else begin
                                n_vcnt = r_vcnt + 1'b1;
                            end
                        end else begin
                            n_acc  = '0;
                            n_vcnt = '0;
                            case (r_vidx)
                                2'd0:    n_shared = acc_new;
                                2'd1:    n_delta  = acc_new;
                                default: n_value  = acc_new;
                            endcase
                            if (r_vidx < pkbe_pkg::VARINT_LAST_IDX) begin
                                if (last) begin
                                    err = pkbe_pkg::ERR_BAD_VARINT;
                                end else begin
                                    n_vidx = r_vidx + 1'b1;
                                end
                            end else begin
                                n_vidx = '0;
                                if (overrun) begin
                                    err = pkbe_pkg::ERR_OVERRUN;
                                end else if (r_shared > r_prev) begin
                                    err = pkbe_pkg::ERR_PREFIX_LONG;
                                end else begin
                                    res.header_done = 1'b1;
                                    // The key length is final once the header is.
                                    n_prev = key_len_sat;
                                    if (r_delta != '0) begin
                                        n_phase   = pkbe_pkg::PH_KEY;
                                        n_left    = r_delta[RB-1:0];
                                        n_key_pos = r_shared[pkbe_pkg::KEY_POS_W-1:0];
                                    end else if (acc_new != '0) begin
                                        n_phase = pkbe_pkg::PH_VALUE;
                                        n_left  = acc_new[RB-1:0];
                                    end else begin
                                        res.entry_done = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    if (err != pkbe_pkg::ERR_NONE) begin
                        n_phase = pkbe_pkg::PH_ERROR;
                    end
                end
            endcase

            res.err = err;
            if (r_phase != pkbe_pkg::PH_ERROR) begin
                res.shared_len = n_shared;
                res.delta_len  = n_delta;
                res.value_len  = n_value;
            end
            n_offset = r_offset + 1'b1;
            if (last) begin
                res.region_done = 1'b1;
                clear           = 1'b1;
            end
        end

        if (clear) begin
            n_offset  = '0;
            n_phase   = pkbe_pkg::PH_HEADER;
            n_vidx    = '0;
            n_vcnt    = '0;
            n_acc     = '0;
            n_shared  = '0;
            n_delta   = '0;
            n_value   = '0;
            n_prev    = '0;
            n_left    = '0;
            n_key_pos = '0;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_phase   <= pkbe_pkg::PH_HEADER;
            r_vidx    <= '0;
            r_vcnt    <= '0;
            r_acc     <= '0;
            r_shared  <= '0;
            r_delta   <= '0;
            r_value   <= '0;
            r_prev    <= '0;
            r_left    <= '0;
            r_key_pos <= '0;
        end else if (i_step) begin
            r_offset  <= n_offset;
            r_phase   <= n_phase;
            r_vidx    <= n_vidx;
            r_vcnt    <= n_vcnt;
            r_acc     <= n_acc;
            r_shared  <= n_shared;
            r_delta   <= n_delta;
            r_value   <= n_value;
            r_prev    <= n_prev;
            r_left    <= n_left;
            r_key_pos <= n_key_pos;
        end
    end

endmodule

// ===== rtl/core/prefix_key_block_entry_parser_unit.sv =====
// ============================================================================
// prefix_key_block_entry_parser_unit
// Byte-serial decoder for the entry region of a prefix-compressed key-value
// block.
// ============================================================================
// The unit takes one byte of the entry region per item and returns one result
// item per byte, tagging it as header, key delta, value or discarded, along
// with the lengths of the current entry and the position of key bytes in the
// rebuilt key. It sustains one item per clock cycle while the output is not
// stalled. An accepted item is held in the input register, and the parse step
// then runs as combinational logic into the result register. The parse state
// is updated on the same edge that loads the result register, which sets the
// rate. The output register holds a finished item while the next byte is
// taken, so a stall on the output side lets one more item in before the input
// backs up.
// Write region_length only while no item is in flight; after the last byte of
// the region, or after any byte outside it, the parser returns to its reset
// state and is ready for the next block.
module prefix_key_block_entry_parser_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pkbe_pkg::CFG_W-1:0]      i_cfg_wr_data,
    pkbe_in_if.sink                         i_byte_ch,
    pkbe_out_if.source                      o_res_ch
);

    localparam int RB = pkbe_pkg::REGION_BITS;

    // Region length register, kept at the counter width.
    logic [RB-1:0]                  r_region_len;
    logic [RB+pkbe_pkg::CFG_W-1:0]  cfg_ext;

    // Input register stage.
    logic                           r_in_valid;
    logic [pkbe_pkg::BYTE_W-1:0]    r_in_byte;

    // Result register stage.
    logic                           r_out_valid;
    pkbe_pkg::t_result              r_out;

    logic                           step;
    pkbe_pkg::t_result              step_res;

    // The held byte moves into the parser whenever the result register is
    // free or is being emptied in this same cycle.
    assign step            = r_in_valid && (!r_out_valid || o_res_ch.ready);
    assign i_byte_ch.ready = !r_in_valid || step;

    assign cfg_ext = {{RB{1'b0}}, i_cfg_wr_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_len <= '0;
        end else if (i_cfg_wr_en) begin
            r_region_len <= cfg_ext[RB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_in_valid <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_ch.ready && i_byte_ch.valid) begin
            r_in_byte <= i_byte_ch.data_byte;
        end
    end

    // The parse step updates its state only on the cycle a byte goes through.
    pkbe_parse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_region_len (r_region_len),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.byte_role    = r_out.role;
    assign o_res_ch.data_out     = r_out.data;
    assign o_res_ch.key_position = r_out.key_pos;
    assign o_res_ch.shared_len   = r_out.shared_len;
    assign o_res_ch.delta_len    = r_out.delta_len;
    assign o_res_ch.value_len    = r_out.value_len;
    assign o_res_ch.header_done  = r_out.header_done;
    assign o_res_ch.entry_done   = r_out.entry_done;
    assign o_res_ch.region_done  = r_out.region_done;
    assign o_res_ch.error_code   = r_out.err;

endmodule

// ===== sim/prefix_key_block_entry_parser_unit_test.sv =====
// ============================================================================
// prefix_key_block_entry_parser_unit_test
// Self-checking bench for the byte-serial block entry parser. A clocked driver
// feeds bytes from a queue and predicts each result as the byte is accepted.
// A clocked monitor compares every result, field by field, in arrival order.
// ============================================================================
module prefix_key_block_entry_parser_unit_test;
    import pkbe_pkg::*;

    // The slowest correct run is roughly 600 items while the receiver idles
    // most of the time. Add one long receiver hold and the drain before every
    // configuration write, and the limit below still leaves ample margin.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_CYCLES  = 250;
    localparam int TAIL_CYCLES  = 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    pkbe_in_if  in_ch();
    pkbe_out_if res_ch();

    prefix_key_block_entry_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_byte_ch     (in_ch),
        .o_res_ch      (res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bytes waiting to be offered, and results predicted but not yet seen.
    logic [BYTE_W-1:0] pending_bytes[$];
    t_result           awaited_results[$];

    // Idle percentages of each side. The main sequence changes them by phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The long receiver hold is armed once and then runs on its own counter.
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    bit hold_on = 1'b0;
    int hold_left = 0;

    int cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int bytes_sent = 0;
    int regions_run = 0;
    int headers_seen = 0;
    int entries_seen = 0;
    int errors_seen[5] = '{default: 0};

    // ------------------------------------------------------------------------
    // Parser prediction. This is the bench's own copy of the parse state and
    // of the region length register, kept at wide widths so that sums such as
    // delta plus value never wrap.
    // ------------------------------------------------------------------------
    logic [63:0] reg_len;
    logic [63:0] reg_off;
    t_phase      parse_ph;
    logic [1:0]  vint_idx;
    logic [2:0]  vint_cnt;
    logic [63:0] vint_acc;
    logic [63:0] cur_sh;
    logic [63:0] cur_dl;
    logic [63:0] cur_vl;
    logic [63:0] prev_klen;
    logic [63:0] bytes_left;

    function automatic void clear_parse();
        reg_off    = '0;
        parse_ph   = PH_HEADER;
        vint_idx   = '0;
        vint_cnt   = '0;
        vint_acc   = '0;
        cur_sh     = '0;
        cur_dl     = '0;
        cur_vl     = '0;
        prev_klen  = '0;
        bytes_left = '0;
    endfunction

    // The full key length saturates at the largest 32-bit value.
    function automatic void close_key();
        logic [63:0] k;
        k = cur_sh + cur_dl;
        prev_klen = (k > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : k;
    endfunction

    function automatic t_result parse_byte(input logic [BYTE_W-1:0] din);
        t_result     r;
        logic        was_err;
        logic        last;
        logic [63:0] left_after;
        logic [63:0] done_len;
        logic [63:0] kp_full;
        r = '0;
        r.data = din;
        r.role = ROLE_HEADER;
        r.err = ERR_NONE;
        was_err = (parse_ph == PH_ERROR);
        if (reg_off >= reg_len) begin
            // Outside the region: discard and start over.
            r.role = ROLE_DISCARD;
            r.region_done = 1'b1;
            clear_parse();
        end else begin
            last = (reg_off + 1 == reg_len);
            left_after = reg_len - reg_off - 1;
            case (parse_ph)
                PH_ERROR: begin
                    r.role = ROLE_DISCARD;
                end
                PH_KEY: begin
                    r.role = ROLE_KEY;
                    kp_full = cur_sh + cur_dl - bytes_left;
                    r.key_pos = kp_full[KEY_POS_W-1:0];
                    bytes_left--;
                    if (bytes_left == 0) begin
                        close_key();
                        if (cur_vl != 0) begin
                            parse_ph = PH_VALUE;
                            bytes_left = cur_vl;
                        end else begin
                            r.entry_done = 1'b1;
                            parse_ph = PH_HEADER;
                        end
                    end
                end
                PH_VALUE: begin
                    r.role = ROLE_VALUE;
                    bytes_left--;
                    if (bytes_left == 0) begin
                        r.entry_done = 1'b1;
                        parse_ph = PH_HEADER;
                    end
                end
                default: begin
                    // First byte of a header clears the lengths and checks
                    // that three bytes remain for the three varints.
                    if (vint_idx == 2'd0 && vint_cnt == 3'd0) begin
                        cur_sh = '0;
                        cur_dl = '0;
                        cur_vl = '0;
                        vint_acc = '0;
                        if (reg_len - reg_off < MIN_HEADER_BYTES)
                            r.err = ERR_SHORT_HEADER;
                    end
                    if (r.err == ERR_NONE) begin
                        vint_acc = (vint_acc | (64'(din[6:0]) << (7 * vint_cnt)))
                                   & 64'hFFFF_FFFF;
                        if (din[7]) begin
                            if (vint_cnt >= VARINT_LAST_BYTE || last)
                                r.err = ERR_BAD_VARINT;
                            else
                                vint_cnt++;
                        end else begin
                            done_len = vint_acc;
                            vint_acc = '0;
                            vint_cnt = '0;
                            case (vint_idx)
                                2'd0:    cur_sh = done_len;
                                2'd1:    cur_dl = done_len;
                                default: cur_vl = done_len;
                            endcase
                            if (vint_idx != VARINT_LAST_IDX) begin
                                if (last)
                                    r.err = ERR_BAD_VARINT;
                                else
                                    vint_idx++;
                            end else begin
                                vint_idx = '0;
                                // Overrun is checked first and wins over a
                                // shared prefix that is too long.
                                if (cur_dl + cur_vl > left_after) begin
                                    r.err = ERR_OVERRUN;
                                end else if (cur_sh > prev_klen) begin
                                    r.err = ERR_PREFIX_LONG;
                                end else begin
                                    r.header_done = 1'b1;
                                    if (cur_dl != 0) begin
                                        parse_ph = PH_KEY;
                                        bytes_left = cur_dl;
                                    end else if (cur_vl != 0) begin
                                        close_key();
                                        parse_ph = PH_VALUE;
                                        bytes_left = cur_vl;
                                    end else begin
                                        close_key();
                                        r.entry_done = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    if (r.err != ERR_NONE)
                        parse_ph = PH_ERROR;
                end
            endcase
            if (!was_err) begin
                r.shared_len = cur_sh[LEN_W-1:0];
                r.delta_len  = cur_dl[LEN_W-1:0];
                r.value_len  = cur_vl[LEN_W-1:0];
            end
            reg_off = (reg_off + 1) & ((64'd1 << REGION_BITS) - 1);
            if (last) begin
                r.region_done = 1'b1;
                clear_parse();
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Byte driver. A new item is offered only when the channel is free, so the
    // valid line is never lowered and raised again within one edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                awaited_results.push_back(parse_byte(in_ch.data_byte));
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= pending_bytes.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold. It starts once armed and once the sender has enough
    // bytes queued to fill the unit and back up its input, then counts down.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            hold_on <= (hold_left != 0);
        end else if (hold_armed && !hold_done && pending_bytes.size() >= 4) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            hold_on <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and receiver back-pressure.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on result %0d, %s: expected %h, got %h",
                         results_seen, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result with nothing expected: data %h, role %0d",
                                 res_ch.data_out, res_ch.byte_role);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("byte_role", 32'(want.role), 32'(res_ch.byte_role));
                    check_field("data_out", 32'(want.data), 32'(res_ch.data_out));
                    check_field("key_position", 32'(want.key_pos),
                                32'(res_ch.key_position));
                    check_field("shared_len", want.shared_len, res_ch.shared_len);
                    check_field("delta_len", want.delta_len, res_ch.delta_len);
                    check_field("value_len", want.value_len, res_ch.value_len);
                    check_field("header_done", 32'(want.header_done),
                                32'(res_ch.header_done));
                    check_field("entry_done", 32'(want.entry_done),
                                32'(res_ch.entry_done));
                    check_field("region_done", 32'(want.region_done),
                                32'(res_ch.region_done));
                    check_field("error_code", 32'(want.err), 32'(res_ch.error_code));
                    headers_seen += want.header_done;
                    entries_seen += want.entry_done;
                    errors_seen[want.err]++;
                end
                results_seen++;
            end
            if (hold_on) begin
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still awaited",
                     cycles, awaited_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] region_bytes[$];

    // Waits until no byte is queued, offered or still on its way through.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_ch.valid || awaited_results.size() != 0);
    endtask

    // Writes region_length; only called with nothing in flight.
    task automatic start_region(input logic [CFG_W-1:0] len);
        wait_idle();
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        reg_len = 64'(len);
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        regions_run++;
    endtask

    task automatic feed(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_sent++;
    endtask

    // LEB128 encoding, sometimes padded to a longer form than needed. A fifth
    // byte gets junk in the bits that fall beyond 32.
    task automatic push_varint(input logic [31:0] v);
        logic [63:0]       w;
        logic [BYTE_W-1:0] b;
        int                n;
        w = 64'(v);
        n = 1;
        while (n < 5 && (w >> (7 * n)) != 0)
            n++;
        if ($urandom_range(9) == 0)
            n = $urandom_range(5, n);
        for (int i = 0; i < n; i++) begin
            b = {1'b0, w[7*i +: 7]};
            if (i == 4)
                b[6:4] = 3'($urandom_range(7));
            b[7] = (i < n - 1);
            region_bytes.push_back(b);
        end
    endtask

    // Builds a region of mostly well-formed entries with random content; some
    // entries carry a deliberate fault, after which the rest is discarded.
    task automatic make_region();
        int          n_ent;
        int          kind;
        logic [31:0] sh;
        logic [31:0] dl;
        logic [31:0] vl;
        logic [31:0] klen;
        region_bytes.delete();
        klen = 0;
        n_ent = $urandom_range(1, 4);
        for (int e = 0; e < n_ent; e++) begin
            kind = $urandom_range(99);
            sh = (klen == 0) ? 0 : $urandom_range(klen, 0);
            dl = $urandom_range(6, 0);
            vl = $urandom_range(6, 0);
            if (kind < 4) begin
                // Varint that never terminates within five bytes.
                repeat (5)
                    region_bytes.push_back(8'h80 | 8'($urandom_range(127)));
                break;
            end
            if (kind < 9)
                sh = klen + $urandom_range(3, 1);
            else if (kind < 13)
                dl = $urandom;
            else if (kind < 16)
                vl = 32'hFFFF_FFFF;
            push_varint(sh);
            push_varint(dl);
            push_varint(vl);
            if (kind < 16)
                break;
            repeat (dl + vl)
                region_bytes.push_back(8'($urandom_range(255)));
            klen = sh + dl;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int len;
        int extra;
        int pick;
        int random_sent;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        res_ch.ready = 1'b0;
        reg_len = '0;
        clear_parse();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Region length is zero after reset, so this byte is outside a region.
        feed(8'hFF);

        // Smallest complete entry: three zero lengths.
        start_region(3);
        feed(8'h00);
        feed(8'h00);
        feed(8'h00);

        // Header that starts with only two bytes left in the region.
        start_region(2);
        feed(8'h00);
        feed(8'h7F);

        // Varint with its continuation bit still set on the fifth byte.
        start_region(5);
        feed(8'h80);
        feed(8'hFF);
        feed(8'h80);
        feed(8'hFF);
        feed(8'h80);

        // Shared prefix too long and lengths overrunning: overrun is reported.
        start_region(3);
        feed(8'h01);
        feed(8'h01);
        feed(8'h00);

        // Largest region length, then a shorter one written while the value
        // field is still open, so the region ends on the last byte of that field.
        start_region(24'hFF_FFFF);
        feed(8'h00);
        feed(8'h02);
        feed(8'h03);
        feed(8'hAA);
        feed(8'h55);
        feed(8'h11);
        feed(8'h22);
        start_region(8);
        feed(8'h33);

        // Random regions in three idling phases.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 83;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_armed = 1'b1;
            end
            make_region();
            pick = $urandom_range(99);
            if (pick < 65)
                len = region_bytes.size();
            else if (pick < 75)
                len = region_bytes.size() + $urandom_range(4, 1);
            else if (pick < 85)
                len = $urandom_range(region_bytes.size(), 1);
            else if (pick < 90)
                len = 0;
            else begin
                region_bytes.delete();
                len = $urandom_range(40, 1);
            end
            extra = ($urandom_range(9) == 0 || len == 0) ? $urandom_range(2, 1) : 0;
            start_region(CFG_W'(len));
            for (int i = 0; i < len + extra; i++) begin
                if (i < region_bytes.size())
                    feed(region_bytes[i]);
                else
                    feed(8'($urandom_range(255)));
            end
            random_sent += len + extra;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (awaited_results.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", awaited_results.size());
        end
        $display("Covered %0d bytes in %0d regions: %0d headers, %0d entries done.",
                 bytes_sent, regions_run, headers_seen, entries_seen);
        $display("Errors seen short/varint/prefix/overrun %0d/%0d/%0d/%0d; %0d mismatches.",
                 errors_seen[ERR_SHORT_HEADER], errors_seen[ERR_BAD_VARINT],
                 errors_seen[ERR_PREFIX_LONG], errors_seen[ERR_OVERRUN], mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== prefix_key_block_entry_parser_unit.f =====
rtl/core/pkbe_pkg.sv
rtl/core/pkbe_if.sv
rtl/core/pkbe_parse_core.sv
rtl/core/prefix_key_block_entry_parser_unit.sv
sim/prefix_key_block_entry_parser_unit_test.sv
